>>> rtl/acsi_pkg.sv
// shared types and constants for the csi escape parser
package acsi_pkg;

  localparam int DIGIT_LIMIT_DEF = 4;
  localparam int DIGIT_LIMIT_MAX = 6;
  localparam int REP_W = $clog2(2 * DIGIT_LIMIT_MAX + 3);
  localparam int ARG_W = 10;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_ESC  = 8'd27;
  localparam logic [7:0] CH_OPEN = 8'd91;
  localparam logic [7:0] CH_SEMI = 8'd59;
  localparam logic [7:0] CH_D    = 8'd68;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;
  localparam logic [7:0] CH_NL   = 8'd10;
  localparam logic [ARG_W-1:0] VALUE_MAX = 10'd999;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  typedef enum logic [4:0] {
    PH_PLAIN  = 5'b00001,
    PH_ESC    = 5'b00010,
    PH_FIRST  = 5'b00100,
    PH_SECOND = 5'b01000,
    PH_SEMIS  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [REP_W-1:0] rep;
    logic             tail_v;
    logic             kind;
    logic [7:0]       ch;
    logic [ARG_W-1:0] a0;
    logic [ARG_W-1:0] a1;
    logic [1:0]       n;
  } job_t;

  typedef struct packed {
    logic             we;
    logic [REP_W-1:0] addr;
    logic [7:0]       data;
  } hold_wr_t;

endpackage

>>> rtl/ansi_csi_escape_parser_core.sv
// top level of the csi escape parser: parser, job queue and output sequencer
// an accepted byte passes the job queue, the current job register and the
// output register; one byte per cycle while intake is not stalled, one result
// per cycle at the output register while out_stall_i is low; a byte that
// replays held text stalls intake until the replay has been emitted
// reset: asynchronous active low, returns to plain text with report mode on
module ansi_csi_escape_parser_core
  import acsi_pkg::*;
#(
  parameter int DIGIT_LIMIT = DIGIT_LIMIT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       in_byte_i,
  input  logic             end_of_text_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             kind_o,
  output logic [7:0]       out_byte_o,
  output logic [ARG_W-1:0] first_arg_o,
  output logic [ARG_W-1:0] second_arg_o,
  output logic [1:0]       arg_count_o,
  output logic             last_of_run_o,
  input  logic             cfg_we_i,
  input  logic             cfg_data_i
);

  logic     push, pop, not_empty, full, replay_done;
  job_t     job, head;
  hold_wr_t hold_wr;

  acsi_front #(.DIGIT_LIMIT(DIGIT_LIMIT)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .q_full_i      (full),
    .replay_done_i (replay_done),
    .push_o        (push),
    .job_o         (job),
    .hold_wr_o     (hold_wr)
  );

  acsi_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (not_empty),
    .full_o      (full)
  );

  acsi_back #(.DIGIT_LIMIT(DIGIT_LIMIT)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .hold_wr_i     (hold_wr),
    .head_i        (head),
    .not_empty_i   (not_empty),
    .pop_o         (pop),
    .replay_done_o (replay_done),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .first_arg_o   (first_arg_o),
    .second_arg_o  (second_arg_o),
    .arg_count_o   (arg_count_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

>>> rtl/acsi_front.sv
// request intake: parses the byte stream and issues output jobs
module acsi_front
  import acsi_pkg::*;
#(
  parameter int DIGIT_LIMIT = DIGIT_LIMIT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  logic       q_full_i,
  input  logic       replay_done_i,
  output logic       push_o,
  output job_t       job_o,
  output hold_wr_t   hold_wr_o
);

  localparam int HOLD_DEPTH = 2 * DIGIT_LIMIT + 2;
  localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
  localparam int DCNT_W = $clog2(DIGIT_LIMIT);

  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic [ARG_W-1:0]  fv_q, fv_d, sv_q, sv_d;
  logic [DCNT_W-1:0] dc_q, dc_d;
  logic [1:0]        vc_q, vc_d;
  logic              report_q;
  logic              wait_q, wait_d;
  logic              accept, dig, semi;
  logic              do_digit, do_plain, do_cmd;
  job_t              job;
  hold_wr_t          wr;

  function automatic logic [ARG_W-1:0] acc(input logic [ARG_W-1:0] v, input logic [7:0] c);
    logic [13:0] r;
    r = {4'd0, v} * 14'd10 + {10'd0, c[3:0]};
    return (r > {4'd0, VALUE_MAX}) ? VALUE_MAX : r[ARG_W-1:0];
  endfunction

  assign in_stall_o = q_full_i | wait_q;
  assign accept = in_valid_i & ~in_stall_o;
  assign dig = (in_byte_i >= CH_ZERO) && (in_byte_i <= CH_NINE);
  assign semi = (in_byte_i == CH_SEMI);

  always_comb begin
    phase_d = phase_q;
    held_d = held_q;
    fv_d = fv_q;
    sv_d = sv_q;
    dc_d = dc_q;
    vc_d = vc_q;
    job = '0;
    job.ch = in_byte_i;
    wr = '0;
    wr.data = in_byte_i;
    do_digit = 1'b0;
    do_plain = 1'b0;
    do_cmd = 1'b0;

    unique case (phase_q)
      PH_ESC: begin
        if (in_byte_i == CH_OPEN) begin
          wr.we = 1'b1;
          wr.addr = REP_W'(held_d);
          held_d = held_d + 1'b1;
          phase_d = PH_FIRST;
          fv_d = '0;
          sv_d = '0;
          dc_d = '0;
          vc_d = '0;
        end else begin
          job.rep = REP_W'(held_q);
          held_d = '0;
          phase_d = PH_PLAIN;
          do_plain = 1'b1;
        end
      end
      PH_FIRST: begin
        if (dig) begin
          do_digit = 1'b1;
        end else begin
          vc_d = (dc_q != '0) ? 2'd1 : 2'd0;
          if (dc_q == '0) fv_d = '0;
          if (semi) begin
            wr.we = 1'b1;
            wr.addr = REP_W'(held_d);
            held_d = held_d + 1'b1;
            dc_d = '0;
            sv_d = '0;
            phase_d = PH_SECOND;
          end else begin
            do_cmd = 1'b1;
          end
        end
      end
      PH_SECOND: begin
        if (dig) begin
          do_digit = 1'b1;
        end else begin
          if (dc_q != '0) begin
            if (vc_q == 2'd0) begin
              fv_d = sv_q;
              sv_d = '0;
            end
            vc_d = vc_q + 2'd1;
          end else begin
            sv_d = '0;
          end
          held_d = '0;
          if (semi) phase_d = PH_SEMIS;
          else do_cmd = 1'b1;
        end
      end
      PH_SEMIS: begin
        if (!semi) do_cmd = 1'b1;
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_digit) begin
      if (dc_q == DCNT_W'(DIGIT_LIMIT - 1)) begin
        job.rep = REP_W'(held_q);
        held_d = '0;
        job.tail_v = 1'b1;
        phase_d = PH_PLAIN;
      end else begin
        if (phase_q == PH_FIRST) fv_d = acc(fv_q, in_byte_i);
        else sv_d = acc(sv_q, in_byte_i);
        dc_d = dc_q + 1'b1;
        wr.we = 1'b1;
        wr.addr = REP_W'(held_d);
        held_d = held_d + 1'b1;
      end
    end

    if (do_plain) begin
      phase_d = PH_PLAIN;
      if (in_byte_i == CH_ESC) begin
        wr.we = 1'b1;
        wr.addr = '0;
        held_d = CNT_W'(1);
        phase_d = PH_ESC;
      end else begin
        job.tail_v = 1'b1;
      end
    end

    if (do_cmd) begin
      if (report_q) begin
        job.tail_v = 1'b1;
        job.kind = KIND_CMD;
        job.a0 = fv_d;
        job.a1 = sv_d;
        job.n = vc_d;
      end else if (in_byte_i == CH_D) begin
        job.tail_v = 1'b1;
        job.ch = CH_NL;
      end
      held_d = '0;
      phase_d = PH_PLAIN;
    end

    if (end_of_text_i) begin
      if (phase_d == PH_ESC) begin
        job.tail_v = 1'b1;
        job.kind = KIND_TEXT;
        job.ch = CH_ESC;
      end
      phase_d = PH_PLAIN;
      held_d = '0;
      dc_d = '0;
      vc_d = '0;
      fv_d = '0;
      sv_d = '0;
    end
  end

  assign push_o = accept & ((job.rep != '0) | job.tail_v);
  assign job_o = job;
  assign hold_wr_o = '{we: accept & wr.we, addr: wr.addr, data: wr.data};

  always_comb begin
    wait_d = wait_q;
    if (replay_done_i) wait_d = 1'b0;
    if (push_o && job.rep != '0) wait_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PLAIN;
      held_q <= '0;
      fv_q <= '0;
      sv_q <= '0;
      dc_q <= '0;
      vc_q <= '0;
      report_q <= 1'b1;
      wait_q <= 1'b0;
    end else begin
      wait_q <= wait_d;
      if (cfg_we_i) report_q <= cfg_data_i;
      if (accept) begin
        phase_q <= phase_d;
        held_q <= held_d;
        fv_q <= fv_d;
        sv_q <= sv_d;
        dc_q <= dc_d;
        vc_q <= vc_d;
      end
    end
  end

endmodule

>>> rtl/acsi_queue.sv
// job queue between parser and output sequencer
module acsi_queue
  import acsi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  input  logic pop_i,
  output job_t head_o,
  output logic not_empty_o,
  output logic full_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_q, rp_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_pop;

  assign not_empty_o = (cnt_q != '0);
  assign full_o = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign head_o = mem_q[rp_q];
  assign do_pop = pop_i & not_empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (do_pop) rp_q <= (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(do_pop);
    end
  end

endmodule

>>> rtl/acsi_back.sv
// output sequencer: replays held bytes and emits result requests
module acsi_back
  import acsi_pkg::*;
#(
  parameter int DIGIT_LIMIT = DIGIT_LIMIT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hold_wr_t         hold_wr_i,
  input  job_t             head_i,
  input  logic             not_empty_i,
  output logic             pop_o,
  output logic             replay_done_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             kind_o,
  output logic [7:0]       out_byte_o,
  output logic [ARG_W-1:0] first_arg_o,
  output logic [ARG_W-1:0] second_arg_o,
  output logic [1:0]       arg_count_o,
  output logic             last_of_run_o
);

  localparam int HOLD_DEPTH = 2 * DIGIT_LIMIT + 2;
  localparam int IDX_W = $clog2(HOLD_DEPTH);

  logic [7:0]       held_q [HOLD_DEPTH];
  job_t             cur_q;
  logic             cur_v_q;
  logic [REP_W-1:0] idx_q;
  logic             out_v_q, kind_q, last_q;
  logic [7:0]       byte_q;
  logic [ARG_W-1:0] a0_q, a1_q;
  logic [1:0]       n_q;
  logic             out_free, in_rep, item_last, step;

  assign out_free = ~out_v_q | ~out_stall_i;
  assign in_rep = (idx_q < cur_q.rep);
  assign item_last = in_rep ? ((idx_q == cur_q.rep - 1'b1) & ~cur_q.tail_v) : 1'b1;
  assign step = cur_v_q & out_free;
  assign pop_o = not_empty_i & (~cur_v_q | (step & item_last));
  assign replay_done_o = step & item_last & (cur_q.rep != '0);

  always_ff @(posedge clk_i) begin
    if (hold_wr_i.we) held_q[hold_wr_i.addr[IDX_W-1:0]] <= hold_wr_i.data;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
    if (step) begin
      last_q <= item_last;
      if (in_rep) begin
        kind_q <= KIND_TEXT;
        byte_q <= held_q[idx_q[IDX_W-1:0]];
        a0_q <= '0;
        a1_q <= '0;
        n_q <= '0;
      end else begin
        kind_q <= cur_q.kind;
        byte_q <= cur_q.ch;
        a0_q <= cur_q.a0;
        a1_q <= cur_q.a1;
        n_q <= cur_q.n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      idx_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (out_free) out_v_q <= cur_v_q;
      if (pop_o) begin
        cur_v_q <= 1'b1;
        idx_q <= '0;
      end else if (step) begin
        if (item_last) cur_v_q <= 1'b0;
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign kind_o = kind_q;
  assign out_byte_o = byte_q;
  assign first_arg_o = a0_q;
  assign second_arg_o = a1_q;
  assign arg_count_o = n_q;
  assign last_of_run_o = last_q;

endmodule
